/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous active-low reset as disable
`define FRQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("frq assertion failed");

// same, written as antecedent and consequent with overlapping implication
`define FRQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  `FRQ_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// same, with the consequent checked in the cycle after the antecedent
`define FRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  `FRQ_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

/* rtl/frq_pkg.sv */
// shared types and constants of the floor request queue
package frq_pkg;

  localparam int unsigned FLOORS  = 4;
  localparam int unsigned FLOOR_W = $clog2(FLOORS);
  localparam int unsigned CNT_W   = $clog2(FLOORS + 1);
  localparam int unsigned MASK_W  = 4;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_DEL = 1'b1;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_ADD,
    OP_DEL
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_DEL,
    ST_RESP
  } frq_state_e;

  // one queue slot
  typedef struct packed {
    logic               used;
    logic [FLOOR_W-1:0] floor;
  } slot_t;

  // command broadcast to every cell
  typedef struct packed {
    cell_op_e           op;
    logic [FLOOR_W-1:0] floor;
  } cell_ctl_t;

  // status rippling from a cell to the next one down the row
  typedef struct packed {
    logic settled;  // add: floor already queued or slot claimed upstream
    logic found;    // delete: target matched upstream
  } cell_link_t;

endpackage

/* rtl/frq_cell.sv */
// one slot of the queue: holds a floor and takes part in add and delete
module frq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  frq_pkg::cell_ctl_t ctl_i,
  input  frq_pkg::cell_link_t link_i,
  output frq_pkg::cell_link_t link_o,
  input  frq_pkg::slot_t     next_i,
  output frq_pkg::slot_t     slot_o
);
  import frq_pkg::*;

  slot_t slot_q, slot_d;
  logic  match;

  assign match = slot_q.used && (slot_q.floor == ctl_i.floor);

  always_comb begin
    slot_d         = slot_q;
    link_o.settled = link_i.settled | match | ~slot_q.used;
    link_o.found   = link_i.found | match;
    case (ctl_i.op)
      OP_ADD: begin
        // queue is packed, so the first free slot is the first unused cell
        if (!slot_q.used && !link_i.settled) begin
          slot_d.used  = 1'b1;
          slot_d.floor = ctl_i.floor;
        end
      end
      OP_DEL: begin
        // matched here or upstream: pull in the neighbor's entry
        if (link_i.found || match) begin
          slot_d = next_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

/* rtl/frq_chain.sv */
// row of queue cells, slot 0 at the head
module frq_chain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  frq_pkg::cell_ctl_t ctl_i,
  output frq_pkg::slot_t     slots_o [frq_pkg::FLOORS]
);
  import frq_pkg::*;

  cell_link_t link [FLOORS+1];
  slot_t      slot [FLOORS+1];

  assign link[0]      = '0;
  assign slot[FLOORS] = '0;  // empty slot shifts into the tail

  for (genvar i = 0; i < FLOORS; i++) begin : g_cell
    frq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl_i),
      .link_i (link[i]),
      .link_o (link[i+1]),
      .next_i (slot[i+1]),
      .slot_o (slot[i])
    );
    assign slots_o[i] = slot[i];
  end

endmodule

/* rtl/floor_request_ordered_queue_top.sv */
// top level of the arrival-ordered floor request queue
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tuser: cmd; tdata: mask, cur, target
//  m_axis   out  m_axis_tvalid / m_axis_tready  tuser: head_valid; tdata: head, count, pend
//
// an add item scans the button mask: the scan visits one floor a cycle
// a delete item makes one shift pass through the cell row
// one item at a time: s_axis_tready is high only while the sequencer is idle
// the result register decouples the sides; a stalled result holds the next
//   item in the response state until the sink takes it
// reset empties the queue at once, no clearing pass
module floor_request_ordered_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [3:0] button_mask, [5:4] current_floor,
                                      // [7:6] target_floor
  input  logic        s_axis_tuser,   // [0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [1:0] head_floor, [4:2] queued_count,
                                      // [8:5] pending_mask, [15:9] zero
  output logic        m_axis_tuser    // [0] head_valid
);
  import frq_pkg::*;

  localparam logic [FLOOR_W-1:0] LAST_FLOOR = FLOOR_W'(FLOORS - 1);

  frq_state_e state_q, state_d;

  // latched item
  logic [MASK_W-1:0]  mask_q;
  logic [FLOOR_W-1:0] cur_q;
  logic [FLOOR_W-1:0] tgt_q;
  logic [FLOOR_W-1:0] scan_q;

  logic       accept;
  logic       load_out;
  cell_ctl_t  ctl;
  slot_t      slots [FLOORS];

  // summary of the queue
  logic [CNT_W-1:0]  count;
  logic [MASK_W-1:0] pend;
  logic [FLOOR_W-1:0] head;
  logic              head_valid;

  // result register
  logic              m_valid_q;
  logic [15:0]       m_data_q;
  logic              m_user_q;

  assign accept = s_axis_tvalid && s_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (s_axis_tuser == CMD_DEL) ? ST_DEL : ST_ADD;
        end
      end
      ST_ADD: begin
        if (scan_q == LAST_FLOOR) begin
          state_d = ST_RESP;
        end
      end
      ST_DEL: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs: cell command and handshake
  always_comb begin
    s_axis_tready = 1'b0;
    load_out      = 1'b0;
    ctl.op        = OP_NOP;
    ctl.floor     = scan_q;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
      end
      ST_ADD: begin
        // pressed floors in ascending order, current floor skipped
        if (mask_q[scan_q] && (scan_q != cur_q)) begin
          ctl.op = OP_ADD;
        end
      end
      ST_DEL: begin
        ctl.op    = OP_DEL;
        ctl.floor = tgt_q;
      end
      ST_RESP: begin
        load_out = !m_valid_q || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        scan_q <= '0;
      end else if (state_q == ST_ADD) begin
        scan_q <= scan_q + FLOOR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mask_q <= s_axis_tdata[3:0];
      cur_q  <= s_axis_tdata[5:4];
      tgt_q  <= s_axis_tdata[7:6];
    end
  end

  frq_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .slots_o (slots)
  );

  // entries are packed from slot 0, so the head is slot 0
  always_comb begin
    count = '0;
    pend  = '0;
    for (int i = 0; i < FLOORS; i++) begin
      if (slots[i].used) begin
        count = count + CNT_W'(1);
        pend  = pend | (MASK_W'(1) << slots[i].floor);
      end
    end
    head_valid = slots[0].used;
    head       = slots[0].used ? slots[0].floor : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {7'd0, pend, count, head};
      m_user_q <= head_valid;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

/* rtl/frq_checker.sv */
// port-level checks of the floor request queue, bound to the top level
`include "assert_macros.svh"

module frq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // head valid exactly when something is queued
  `FRQ_ASSERT_IMP(a_head_valid, clk_i, rst_ni, m_axis_tvalid,
    m_axis_tuser == (m_axis_tdata[4:2] != 3'd0))

  // count agrees with the pending mask
  `FRQ_ASSERT_IMP(a_count_pend, clk_i, rst_ni, m_axis_tvalid,
    $countones(m_axis_tdata[8:5]) == m_axis_tdata[4:2])

  // the head floor is one of the pending floors
  `FRQ_ASSERT_IMP(a_head_pend, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser,
    ((m_axis_tdata[8:5] >> m_axis_tdata[1:0]) & 4'd1) == 4'd1)

  // one item at a time: input closes after an accept
  `FRQ_ASSERT_NEXT(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
    !s_axis_tready)

  // a stalled result holds
  `FRQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind floor_request_ordered_queue_top frq_checker u_frq_checker (.*);

/* verif/tb.sv */
// self-checking testbench of the arrival-ordered floor request queue
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import frq_pkg::*;

  // one result item as the sink sees it, fields from the highest bit down
  typedef struct packed {
    logic [MASK_W-1:0]  pend;
    logic [CNT_W-1:0]   count;
    logic               head_valid;
    logic [FLOOR_W-1:0] head;
  } queue_status_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [3:0] button_mask, [5:4] current_floor, [7:6] target_floor
  logic        s_axis_tuser;   // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [1:0] head_floor, [4:2] queued_count, [8:5] pending_mask
  logic        m_axis_tuser;   // [0] head_valid

  floor_request_ordered_queue_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // shadow copy of the queue, packed from slot 0 in arrival order
  logic [FLOOR_W-1:0] shadow_floor [FLOORS];
  logic               shadow_used  [FLOORS];
  int                 shadow_depth;

  // statuses predicted for accepted items, oldest first
  queue_status_t awaited_status [$];

  int  error_count;
  int  results_checked;
  int  adds_sent;
  int  deletes_sent;
  int  deletes_absent;
  int  full_seen;
  int  drains_done;
  bit  idle_bursts_on;

  // free-running clock, 10 ns period
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the handshake hangs
  initial begin
    #5ms;
    $display("timeout with %0d results still awaited", awaited_status.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("%t mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    error_count++;
  endtask

  // apply one accepted item to the shadow queue and queue up the status it yields
  task automatic queue_model_apply(input logic cmd, input logic [MASK_W-1:0] mask,
                                   input logic [FLOOR_W-1:0] cur,
                                   input logic [FLOOR_W-1:0] tgt);
    queue_status_t st;
    bit            dup;
    int            hit;
    if (cmd == CMD_ADD) begin
      adds_sent++;
      // scan floors upward; skip the current one and anything already queued
      for (int f = 0; f < FLOORS; f++) begin
        if (mask[f] && f != cur) begin
          dup = 1'b0;
          for (int i = 0; i < FLOORS; i++)
            if (shadow_used[i] && shadow_floor[i] == f) dup = 1'b1;
          if (!dup && shadow_depth < FLOORS) begin
            shadow_floor[shadow_depth] = f[FLOOR_W-1:0];
            shadow_used[shadow_depth]  = 1'b1;
            shadow_depth++;
          end
        end
      end
    end else begin
      deletes_sent++;
      hit = -1;
      for (int i = 0; i < FLOORS; i++)
        if (hit < 0 && shadow_used[i] && shadow_floor[i] == tgt) hit = i;
      if (hit < 0) begin
        deletes_absent++;
      end else begin
        // close the gap: later entries move forward, last slot frees up
        for (int k = hit; k < FLOORS - 1; k++) begin
          shadow_floor[k] = shadow_floor[k + 1];
          shadow_used[k]  = shadow_used[k + 1];
        end
        shadow_floor[FLOORS - 1] = '0;
        shadow_used[FLOORS - 1]  = 1'b0;
        shadow_depth--;
      end
    end
    if (shadow_depth == FLOORS) full_seen++;

    st = '0;
    st.count = shadow_depth[CNT_W-1:0];
    if (shadow_depth > 0) begin
      st.head       = shadow_floor[0];
      st.head_valid = 1'b1;
    end
    for (int i = 0; i < FLOORS; i++)
      if (shadow_used[i]) st.pend[shadow_floor[i]] = 1'b1;
    awaited_status.push_back(st);
  endtask

  // present one item and hold it until the block takes it
  task automatic send_request(input logic cmd, input logic [MASK_W-1:0] mask,
                              input logic [FLOOR_W-1:0] cur,
                              input logic [FLOOR_W-1:0] tgt);
    if (idle_bursts_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {tgt, cur, mask};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    queue_model_apply(cmd, mask, cur, tgt);
  endtask

  // unused fields of each kind of item carry random junk
  task automatic send_add(input logic [MASK_W-1:0] mask, input logic [FLOOR_W-1:0] cur);
    send_request(CMD_ADD, mask, cur, FLOOR_W'($urandom_range(0, FLOORS - 1)));
  endtask

  task automatic send_delete(input logic [FLOOR_W-1:0] tgt);
    send_request(CMD_DEL, MASK_W'($urandom_range(0, 15)),
                 FLOOR_W'($urandom_range(0, FLOORS - 1)), tgt);
  endtask

  // hold off the sender until every awaited status has come back
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaited_status.size() != 0) @(posedge clk_i);
    drains_done++;
  endtask

  // well-formed traffic: adds of random buttons, deletes mostly of queued floors
  task automatic random_items(input int n);
    logic [FLOOR_W-1:0] tgt;
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 9) < 6) begin
        send_add(MASK_W'($urandom_range(0, 15)), FLOOR_W'($urandom_range(0, FLOORS - 1)));
      end else begin
        if (shadow_depth > 0 && $urandom_range(0, 3) != 0)
          tgt = shadow_floor[$urandom_range(0, shadow_depth - 1)];
        else
          tgt = FLOOR_W'($urandom_range(0, FLOORS - 1));
        send_delete(tgt);
      end
    end
  endtask

  // deletes and idle adds while nothing is queued
  task automatic test_empty_queue();
    send_delete(2'd0);
    send_delete(2'd3);
    send_add(4'b0000, 2'd0);
    send_add(4'b0001, 2'd0);
  endtask

  // ascending scan, current floor skipped, duplicates dropped, queue filled
  task automatic test_add_scan();
    send_add(4'b1111, 2'd0);
    send_add(4'b1111, 2'd3);
    send_add(4'b1111, 2'd1);
    send_add(4'b0110, 2'd2);
  endtask

  // removal from head, tail and middle, plus targets not queued
  task automatic test_delete_shift();
    send_delete(2'd1);
    send_delete(2'd0);
    send_add(4'b0001, 2'd2);
    send_delete(2'd3);
    send_delete(2'd3);
    send_add(4'b1000, 2'd3);
    send_add(4'b1010, 2'd0);
    send_delete(2'd2);
    send_delete(2'd0);
    send_delete(2'd1);
    send_delete(2'd3);
    send_delete(2'd3);
  endtask

  // bulk random traffic with occasional full drains in between
  task automatic test_random_traffic();
    for (int blk = 0; blk < 6; blk++) begin
      random_items(240);
      wait_for_drain();
    end
  endtask

  // back-to-back items and an always-ready sink at the end
  task automatic test_quiet_tail();
    idle_bursts_on = 1'b0;
    random_items(180);
  endtask

  // sink side: ready with random stall bursts while enabled
  initial begin
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (idle_bursts_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // compare each accepted result with the oldest awaited status
  always @(posedge clk_i) begin
    queue_status_t exp_st;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (awaited_status.size() == 0) begin
        $display("%t result item with nothing awaited", $realtime);
        error_count++;
      end else begin
        exp_st = awaited_status.pop_front();
        results_checked++;
        if (m_axis_tdata[1:0] !== exp_st.head)
          report_mismatch("head_floor", exp_st.head, m_axis_tdata[1:0]);
        if (m_axis_tuser !== exp_st.head_valid)
          report_mismatch("head_valid", exp_st.head_valid, m_axis_tuser);
        if (m_axis_tdata[4:2] !== exp_st.count)
          report_mismatch("queued_count", exp_st.count, m_axis_tdata[4:2]);
        if (m_axis_tdata[8:5] !== exp_st.pend)
          report_mismatch("pending_mask", exp_st.pend, m_axis_tdata[8:5]);
        if (m_axis_tdata[15:9] !== '0)
          report_mismatch("tdata padding", 0, m_axis_tdata[15:9]);
      end
    end
  end

  initial begin
    int guard;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    m_axis_tready  = 1'b0;
    idle_bursts_on = 1'b1;
    error_count    = 0;
    shadow_depth   = 0;
    for (int i = 0; i < FLOORS; i++) begin
      shadow_floor[i] = '0;
      shadow_used[i]  = 1'b0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_add_scan();
    test_delete_shift();
    test_random_traffic();
    test_quiet_tail();

    // let the last items through before the final check
    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (awaited_status.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (12) @(posedge clk_i);
    if (awaited_status.size() != 0) begin
      $display("%0d statuses never came back", awaited_status.size());
      error_count++;
    end

    $display("checked %0d results: %0d adds, %0d deletes (%0d of floors not queued)",
             results_checked, adds_sent, deletes_sent, deletes_absent);
    $display("queue reached full depth %0d times, sender drained %0d times, %0d mismatches",
             full_seen, drains_done, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
